### design/rfps_pkg.sv
package rfps_pkg;

	localparam int LVL_W   = 17;
	localparam int FRAC_W  = 16;
	localparam int TIME_W  = 32;
	localparam int MP_W    = 16;
	localparam int PER_W   = 20;
	localparam int MUL_W   = 20;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DVD_W   = 34;
	localparam int DCNT_W  = 6;

	localparam logic [LVL_W-1:0]  LVL_ONE  = LVL_W'(1) << FRAC_W;
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);

	localparam logic [DCNT_W-1:0] FRAC_STEPS = DCNT_W'(FRAC_W);
	localparam logic [DCNT_W-1:0] TOT_STEPS  = DCNT_W'(DVD_W);

	localparam logic MODE_FADE = 1'b0;

	localparam logic [1:0] REG_MIN_PHASE   = 2'd0;
	localparam logic [1:0] REG_BASE_PERIOD = 2'd1;
	localparam logic [1:0] REG_MAX_PERIOD  = 2'd2;
	localparam logic [1:0] REG_END_MARGIN  = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_REQ,
		OP_RUN,
		OP_END,
		OP_DIVA,
		OP_RR,
		OP_M1,
		OP_M2,
		OP_M3,
		OP_M4,
		OP_SORT,
		OP_MULB,
		OP_BR,
		OP_TOT,
		OP_SCM,
		OP_SCW
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       merge;
		logic       fin;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic       div_busy;
		logic       no_pwm;
		logic       stretch;
		logic [1:0] gcnt;
	} stat_t;

endpackage

### design/rfps_req_if.sv
interface rfps_req_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [31:0]               now_time;
	logic [31:0]               fade_length;
	logic [rfps_pkg::LVL_W-1:0] target_red;
	logic [rfps_pkg::LVL_W-1:0] target_green;
	logic [rfps_pkg::LVL_W-1:0] target_blue;

	modport source (output valid, mode, now_time, fade_length, target_red, target_green,
		target_blue, input ready);
	modport sink (input valid, mode, now_time, fade_length, target_red, target_green,
		target_blue, output ready);
endinterface

### design/rfps_sched_if.sv
interface rfps_sched_if;
	logic        valid;
	logic        ready;
	logic [1:0]  phase_index;
	logic [2:0]  color_mask;
	logic [19:0] duration;
	logic [2:0]  steady_off_mask;
	logic [2:0]  steady_on_mask;
	logic        fade_done;
	logic        no_pwm;
	logic        last;

	modport source (output valid, phase_index, color_mask, duration, steady_off_mask,
		steady_on_mask, fade_done, no_pwm, last, input ready);
	modport sink (input valid, phase_index, color_mask, duration, steady_off_mask,
		steady_on_mask, fade_done, no_pwm, last, output ready);
endinterface

### design/rfps_ctrl.sv
module rfps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_acc,
	input  logic           mode,
	input  logic           out_acc,
	input  rfps_pkg::stat_t stat,
	output rfps_pkg::cmd_t  cmd,
	output logic           in_ready,
	output logic           out_valid
);
	import rfps_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_REQ, S_RUN, S_END, S_DIVA, S_DIVW, S_RR,
		S_M1, S_M2, S_M3, S_M4, S_SORT, S_MULB, S_BR, S_DIVB,
		S_TOT, S_SCM, S_SCW, S_MERGE, S_FIN, S_EMIT
	} state_t;

	state_t     state_q;
	cmd_t       cmd_q;
	logic       ready_q;
	logic       valid_q;
	logic [1:0] first_g;

	assign first_g = stat.stretch ? 2'd2 : 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '{op: OP_NONE, merge: 1'b0, fin: 1'b0, idx: 2'd0};
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			cmd_q.merge <= 1'b0;
			cmd_q.fin   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cmd_q.op <= OP_NONE;
					if (in_acc) begin
						ready_q <= 1'b0;
						if (mode == MODE_FADE) begin
							cmd_q.op <= OP_REQ;
							state_q  <= S_REQ;
						end else begin
							cmd_q.op <= OP_RUN;
							state_q  <= S_RUN;
						end
					end
				end
				S_REQ: begin
					cmd_q.op <= OP_NONE;
					ready_q  <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_RUN: begin
					cmd_q.op <= OP_END;
					state_q  <= S_END;
				end
				S_END: begin
					cmd_q.op <= OP_DIVA;
					state_q  <= S_DIVA;
				end
				S_DIVA: begin
					cmd_q.op <= OP_NONE;
					state_q  <= S_DIVW;
				end
				S_DIVW: begin
					if (!stat.div_busy) begin
						cmd_q.op <= OP_RR;
						state_q  <= S_RR;
					end
				end
				S_RR: begin
					cmd_q.op  <= OP_M1;
					cmd_q.idx <= 2'd0;
					state_q   <= S_M1;
				end
				S_M1: begin
					cmd_q.op <= OP_M2;
					state_q  <= S_M2;
				end
				S_M2: begin
					cmd_q.op <= OP_M3;
					state_q  <= S_M3;
				end
				S_M3: begin
					cmd_q.op <= OP_M4;
					state_q  <= S_M4;
				end
				S_M4: begin
					if (cmd_q.idx == 2'd2) begin
						cmd_q.op <= OP_SORT;
						state_q  <= S_SORT;
					end else begin
						cmd_q.op  <= OP_M1;
						cmd_q.idx <= cmd_q.idx + 2'd1;
						state_q   <= S_M1;
					end
				end
				S_SORT: begin
					cmd_q.op <= OP_MULB;
					state_q  <= S_MULB;
				end
				S_MULB: begin
					if (stat.no_pwm) begin
						cmd_q.op  <= OP_NONE;
						cmd_q.idx <= 2'd0;
						valid_q   <= 1'b1;
						state_q   <= S_EMIT;
					end else begin
						cmd_q.op <= OP_BR;
						state_q  <= S_BR;
					end
				end
				S_BR: begin
					cmd_q.op <= OP_NONE;
					state_q  <= S_DIVB;
				end
				S_DIVB: begin
					if (!stat.div_busy) begin
						cmd_q.op <= OP_TOT;
						state_q  <= S_TOT;
					end
				end
				S_TOT: begin
					if (first_g > stat.gcnt) begin
						cmd_q.op    <= OP_NONE;
						cmd_q.merge <= 1'b1;
						state_q     <= S_MERGE;
					end else begin
						cmd_q.op  <= OP_SCM;
						cmd_q.idx <= first_g;
						state_q   <= S_SCM;
					end
				end
				S_SCM: begin
					cmd_q.op <= OP_SCW;
					state_q  <= S_SCW;
				end
				S_SCW: begin
					if (cmd_q.idx == stat.gcnt) begin
						cmd_q.op    <= OP_NONE;
						cmd_q.merge <= 1'b1;
						state_q     <= S_MERGE;
					end else begin
						cmd_q.op  <= OP_SCM;
						cmd_q.idx <= cmd_q.idx + 2'd1;
						state_q   <= S_SCM;
					end
				end
				S_MERGE: begin
					cmd_q.op  <= OP_NONE;
					cmd_q.fin <= 1'b1;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					cmd_q.op  <= OP_NONE;
					cmd_q.idx <= 2'd0;
					valid_q   <= 1'b1;
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					cmd_q.op <= OP_NONE;
					if (out_acc) begin
						if (stat.no_pwm || cmd_q.idx == stat.gcnt) begin
							valid_q <= 1'b0;
							ready_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							cmd_q.idx <= cmd_q.idx + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd       = cmd_q;
	assign in_ready  = ready_q;
	assign out_valid = valid_q;
endmodule

### design/rfps_dp.sv
module rfps_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rfps_pkg::cmd_t            cmd,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [19:0]               cfg_data,
	input  logic                      in_acc,
	input  logic [31:0]               now_time,
	input  logic [31:0]               fade_length,
	input  logic [rfps_pkg::LVL_W-1:0] target_red,
	input  logic [rfps_pkg::LVL_W-1:0] target_green,
	input  logic [rfps_pkg::LVL_W-1:0] target_blue,
	output rfps_pkg::stat_t           stat,
	output logic [1:0]                phase_index,
	output logic [2:0]                color_mask,
	output logic [19:0]               duration,
	output logic [2:0]                steady_off_mask,
	output logic [2:0]                steady_on_mask,
	output logic                      fade_done,
	output logic                      no_pwm,
	output logic                      last
);
	import rfps_pkg::*;

	function automatic logic [LVL_W-1:0] clamp(input logic [LVL_W-1:0] x);
		return (x > LVL_ONE) ? LVL_ONE : x;
	endfunction

	function automatic logic [PROD_W-FRAC_W-1:0] rnd(input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] sum;
		sum = p + RND_HALF;
		return sum[PROD_W-1:FRAC_W];
	endfunction

	// b - a below min_phase, signed
	function automatic logic close(input logic [PER_W-1:0] a, input logic [PER_W-1:0] b,
		input logic [MP_W-1:0] mp);
		logic signed [PER_W+1:0] d;
		d = $signed({2'b00, b}) - $signed({2'b00, a});
		return d < $signed({{(PER_W+2-MP_W){1'b0}}, mp});
	endfunction

	logic [MP_W-1:0]   mp_q;
	logic [PER_W-1:0]  bp_q, mx_q, em_q;

	logic [LVL_W-1:0]  st_lv_q [0:2];
	logic [LVL_W-1:0]  tg_lv_q [0:2];
	logic [LVL_W-1:0]  cur_q   [0:2];
	logic [TIME_W-1:0] fstart_q, flen_q;

	logic [TIME_W-1:0] now_q, flen_in_q;
	logic [LVL_W-1:0]  tin_q [0:2];

	logic [TIME_W-1:0] run_q;
	logic              done_q, small_q;
	logic [LVL_W-1:0]  rr_q;
	logic [PROD_W-1:0] prod_q;
	logic [LVL_W-1:0]  lv_q  [0:2];
	logic [LVL_W-1:0]  gl_q  [0:3];
	logic [2:0]        grp_q [0:3];
	logic [PER_W-1:0]  t_q   [0:3];
	logic [1:0]        gcnt_q;
	logic [2:0]        off_q, on_q;
	logic [PER_W-1:0]  total_q;

	logic [TIME_W-1:0] rem_q, dsor_q;
	logic [DVD_W-1:0]  dvd_q, quo_q;
	logic [DCNT_W-1:0] dcnt_q;

	// end check
	logic [TIME_W-1:0] remain;
	logic              end_hit;
	assign remain  = flen_q - run_q;
	assign end_hit = (flen_q != '0) &&
		(remain[TIME_W-1] || remain < {{(TIME_W-PER_W){1'b0}}, em_q});

	// colour curve operands
	logic [LVL_W-1:0] st_c, tg_c, a_c, r2_c, s_c, s2_c;
	logic             up_c, fading_c;
	logic [PROD_W-FRAC_W-1:0] rnd_p;
	assign rnd_p    = rnd(prod_q);
	assign st_c     = clamp(st_lv_q[cmd.idx]);
	assign tg_c     = clamp(tg_lv_q[cmd.idx]);
	assign up_c     = st_c < tg_c;
	assign a_c      = up_c ? st_c : tg_c;
	assign r2_c     = up_c ? rr_q : LVL_ONE - rr_q;
	assign fading_c = (flen_q != '0) && (st_c != tg_c);
	assign s_c      = a_c + rnd_p[LVL_W-1:0];
	assign s2_c     = rnd_p[LVL_W-1:0];

	logic [MUL_W-1:0] ma, mb;
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_M1: begin
				ma = MUL_W'(LVL_ONE - a_c);
				mb = MUL_W'(r2_c);
			end
			OP_M2: begin
				ma = MUL_W'(s_c);
				mb = MUL_W'(s_c);
			end
			OP_M3: begin
				ma = MUL_W'(s2_c);
				mb = MUL_W'(tg_c);
			end
			OP_MULB: begin
				ma = MUL_W'(gl_q[1]);
				mb = bp_q;
			end
			OP_SCM: begin
				ma = total_q;
				mb = MUL_W'(gl_q[cmd.idx]);
			end
			default: ;
		endcase
	end

	// sort and grouping
	logic [1:0]       i0, i1, i2, sw;
	logic [1:0]       sidx [0:2];
	logic [2:0]       n_off, n_on;
	logic [2:0]       n_grp [0:3];
	logic [LVL_W-1:0] n_gl  [0:3];
	logic [1:0]       n_g;
	always_comb begin
		i0 = 2'd0;
		i1 = 2'd1;
		i2 = 2'd2;
		sw = 2'd0;
		if (lv_q[i0] > lv_q[i1]) begin
			sw = i0; i0 = i1; i1 = sw;
		end
		if (lv_q[i1] > lv_q[i2]) begin
			sw = i1; i1 = i2; i2 = sw;
		end
		if (lv_q[i0] > lv_q[i1]) begin
			sw = i0; i0 = i1; i1 = sw;
		end
		sidx[0] = i0;
		sidx[1] = i1;
		sidx[2] = i2;
		n_off = '0;
		n_on  = '0;
		n_g   = '0;
		for (int k = 0; k < 4; k++) begin
			n_grp[k] = '0;
			n_gl[k]  = '0;
		end
		for (int p = 0; p < 3; p++) begin
			if (lv_q[sidx[p]] == '0) begin
				n_off[sidx[p]] = 1'b1;
			end else if (lv_q[sidx[p]] >= LVL_ONE) begin
				n_on[sidx[p]] = 1'b1;
			end else begin
				n_g             = n_g + 2'd1;
				n_grp[n_g]      = 3'b001 << sidx[p];
				n_gl[n_g]       = lv_q[sidx[p]];
			end
		end
	end

	// merging of close groups
	logic [PER_W-1:0] m_t   [0:3];
	logic [2:0]       m_grp [0:3];
	logic [1:0]       m_g;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			m_t[k]   = t_q[k];
			m_grp[k] = grp_q[k];
		end
		m_g = gcnt_q;
		if (m_g >= 2'd2) begin
			if (close(m_t[1], m_t[2], mp_q)) begin
				m_grp[1] = m_grp[1] | m_grp[2];
				m_grp[2] = m_grp[3];
				m_t[2]   = m_t[3];
				m_grp[3] = '0;
				m_t[3]   = '0;
				m_g      = m_g - 2'd1;
				if (m_g >= 2'd2 && close(m_t[1], m_t[2], mp_q)) begin
					m_grp[1] = m_grp[1] | m_grp[2];
					m_grp[2] = '0;
					m_t[2]   = '0;
					m_g      = m_g - 2'd1;
				end
			end else if (m_g == 2'd3 && close(m_t[2], m_t[3], mp_q)) begin
				m_grp[2] = m_grp[2] | m_grp[3];
				m_grp[3] = '0;
				m_t[3]   = '0;
				m_g      = m_g - 2'd1;
			end
		end
	end

	// tail and stored differences
	logic [PER_W-1:0] tl, f_t0, f_t2, f_t3;
	assign tl   = t_q[gcnt_q];
	assign f_t0 = (total_q > tl) ? total_q - tl : '0;
	assign f_t2 = (gcnt_q >= 2'd2) ? t_q[2] - t_q[1] : t_q[2];
	assign f_t3 = (gcnt_q == 2'd3) ? t_q[3] - f_t2 : t_q[3];

	logic [PROD_W-FRAC_W-1:0] sc_r;
	assign sc_r = rnd_p;

	logic [TIME_W:0] trial;
	logic            ge;
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_q <= MP_W'(250);
			bp_q <= PER_W'(5000);
			mx_q <= PER_W'(50000);
			em_q <= PER_W'(5000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_PHASE:   mp_q <= cfg_data[MP_W-1:0];
				REG_BASE_PERIOD: bp_q <= cfg_data;
				REG_MAX_PERIOD:  mx_q <= cfg_data;
				REG_END_MARGIN:  em_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				st_lv_q[c] <= '0;
				tg_lv_q[c] <= '0;
				cur_q[c]   <= '0;
			end
			fstart_q <= '0;
			flen_q   <= '0;
		end else begin
			case (cmd.op)
				OP_REQ: begin
					for (int c = 0; c < 3; c++) begin
						st_lv_q[c] <= cur_q[c];
						tg_lv_q[c] <= tin_q[c];
					end
					fstart_q <= now_q - {{(TIME_W-PER_W){1'b0}}, em_q};
					flen_q   <= (flen_in_q == '0) ? TIME_W'(1) : flen_in_q;
				end
				OP_END: begin
					if (end_hit) begin
						flen_q   <= '0;
						fstart_q <= '0;
						for (int c = 0; c < 3; c++) cur_q[c] <= tg_lv_q[c];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.op == OP_DIVA) begin
			dcnt_q <= (flen_q != '0 && run_q < flen_q) ? FRAC_STEPS : '0;
		end else if (cmd.op == OP_BR) begin
			dcnt_q <= (prod_q < {8'b0, mp_q, 16'b0}) ? TOT_STEPS : '0;
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIVA) begin
			rem_q  <= run_q;
			dvd_q  <= '0;
			quo_q  <= '0;
			dsor_q <= flen_q;
		end else if (cmd.op == OP_BR) begin
			rem_q  <= '0;
			dvd_q  <= {1'b0, mp_q, 17'b0} + DVD_W'(gl_q[1]);
			quo_q  <= '0;
			dsor_q <= {14'b0, gl_q[1], 1'b0};
		end else if (dcnt_q != '0) begin
			rem_q <= ge ? TIME_W'(trial - {1'b0, dsor_q}) : trial[TIME_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q     <= now_time;
			flen_in_q <= fade_length;
			tin_q[0]  <= target_red;
			tin_q[1]  <= target_green;
			tin_q[2]  <= target_blue;
		end
		prod_q <= ma * mb;
		case (cmd.op)
			OP_RUN: run_q <= now_q - fstart_q;
			OP_END: done_q <= end_hit;
			OP_RR: rr_q <= (run_q >= flen_q) ? LVL_ONE : {1'b0, quo_q[FRAC_W-1:0]};
			OP_M4: lv_q[cmd.idx] <= fading_c ? clamp(rnd_p[LVL_W-1:0]) : tg_c;
			OP_SORT: begin
				off_q  <= n_off;
				on_q   <= n_on;
				gcnt_q <= n_g;
				for (int k = 0; k < 4; k++) begin
					grp_q[k] <= n_grp[k];
					gl_q[k]  <= n_gl[k];
					t_q[k]   <= '0;
				end
			end
			OP_BR: small_q <= prod_q < {8'b0, mp_q, 16'b0};
			OP_TOT: begin
				if (small_q) begin
					total_q <= (quo_q > {14'b0, mx_q}) ? mx_q : quo_q[PER_W-1:0];
					t_q[1]  <= {4'b0, mp_q};
				end else begin
					total_q <= bp_q;
				end
			end
			OP_SCW: t_q[cmd.idx] <= (sc_r < {8'b0, mp_q}) ? {4'b0, mp_q} : sc_r[PER_W-1:0];
			default: ;
		endcase
		if (cmd.merge) begin
			gcnt_q <= m_g;
			for (int k = 1; k < 4; k++) begin
				t_q[k]   <= m_t[k];
				grp_q[k] <= m_grp[k];
			end
		end
		if (cmd.fin) begin
			t_q[0]   <= f_t0;
			t_q[2]   <= f_t2;
			t_q[3]   <= f_t3;
			grp_q[0] <= grp_q[1] | grp_q[2] | grp_q[3];
		end
	end

	assign stat.div_busy = dcnt_q != '0;
	assign stat.no_pwm   = gcnt_q == '0;
	assign stat.stretch  = small_q;
	assign stat.gcnt     = gcnt_q;

	assign phase_index     = cmd.idx;
	assign color_mask      = grp_q[cmd.idx];
	assign duration        = t_q[cmd.idx];
	assign steady_off_mask = off_q;
	assign steady_on_mask  = on_q;
	assign fade_done       = done_q;
	assign no_pwm          = gcnt_q == '0;
	assign last            = (gcnt_q == '0) || (cmd.idx == gcnt_q);
endmodule

### design/rgb_fade_pwm_phase_scheduler.sv
// channel   dir  handshake     payload
// req       in   valid/ready   mode, now_time, fade_length, target_red/green/blue
// sched     out  valid/ready   phase_index, color_mask, duration, steady masks,
//                              fade_done, no_pwm, last
// cfg       in   cfg_we        cfg_index, cfg_data
//
// A fade request only loads the fade state and offers no beat. A period request
// uses the fraction divider while a fade is running; if no colour needs PWM it
// offers one beat, else it uses the shift-subtract divider (one bit per cycle)
// when the period is stretched and the shared multiplier per scaled group, then
// offers 2 to 4 beats. One item is in work at a time; req.ready is low until the
// last beat of a period request is taken. arst_n clears the fade state.
module rgb_fade_pwm_phase_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	rfps_req_if.sink    req,
	rfps_sched_if.source sched,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import rfps_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_acc, out_acc;

	assign in_acc  = req.valid & req.ready;
	assign out_acc = sched.valid & sched.ready;

	rfps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.mode      (req.mode),
		.out_acc   (out_acc),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (req.ready),
		.out_valid (sched.valid)
	);

	rfps_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_acc          (in_acc),
		.now_time        (req.now_time),
		.fade_length     (req.fade_length),
		.target_red      (req.target_red),
		.target_green    (req.target_green),
		.target_blue     (req.target_blue),
		.stat            (stat),
		.phase_index     (sched.phase_index),
		.color_mask      (sched.color_mask),
		.duration        (sched.duration),
		.steady_off_mask (sched.steady_off_mask),
		.steady_on_mask  (sched.steady_on_mask),
		.fade_done       (sched.fade_done),
		.no_pwm          (sched.no_pwm),
		.last            (sched.last)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		sched.valid |-> !req.ready)
		else $error("input taken while results pending");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !req.ready)
		else $error("ready stayed high after accept");

	a_nopwm_single: assert property (@(posedge clk) disable iff (!arst_n)
		sched.valid && sched.no_pwm |-> sched.last && sched.phase_index == 2'd0)
		else $error("no-pwm result not a single beat");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && sched.last |=> !sched.valid && req.ready)
		else $error("block not idle after last beat");
endmodule

### verif/rgb_fade_pwm_phase_scheduler_tb.sv
`timescale 1ns / 1ps

module rgb_fade_pwm_phase_scheduler_tb;
	import rfps_pkg::*;

	localparam longint unsigned ONE_L   = 64'd1 << FRAC_W;
	localparam longint unsigned HALF_L  = 64'd1 << (FRAC_W - 1);
	localparam longint unsigned TMASK_L = (64'd1 << TIME_W) - 1;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [1:0]  ph;
		logic [2:0]  mask;
		logic [19:0] dur;
		logic [2:0]  off;
		logic [2:0]  on;
		logic        done;
		logic        nopwm;
		logic        last;
	} phase_beat_t;

	typedef struct {
		logic              mode;
		logic [31:0]       now;
		logic [31:0]       len;
		logic [LVL_W-1:0]  lvl [3];
		int                n_typed;
		phase_beat_t       typed;
	} req_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [19:0] cfg_data;

	rfps_req_if   req_ch ();
	rfps_sched_if sched_ch ();

	rgb_fade_pwm_phase_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.sched(sched_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the block
	longint unsigned sh_min_phase, sh_base, sh_max, sh_margin;
	longint unsigned lvl_start [3], lvl_tgt [3], lvl_cur [3];
	longint unsigned fade_t0, fade_len;

	phase_beat_t sched_q [$];
	int errors = 0;
	int cycles = 0;
	int tx_idle = 0, rx_idle = 0, rx_hold = 0;
	longint unsigned tcur;
	int n_sent;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			sched_ch.ready <= 1'b0;
		end else begin
			sched_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		phase_beat_t got, want;
		if (arst_n && sched_ch.valid && sched_ch.ready) begin
			got = '{sched_ch.phase_index, sched_ch.color_mask, sched_ch.duration,
				sched_ch.steady_off_mask, sched_ch.steady_on_mask, sched_ch.fade_done,
				sched_ch.no_pwm, sched_ch.last};
			if (sched_q.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: exp none act %p", $time, got);
			end else begin
				want = sched_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t beat mismatch: exp %p act %p", $time, want, got);
				end
			end
		end
	end

	function automatic longint unsigned clamp_lvl(longint unsigned x);
		return x > ONE_L ? ONE_L : x;
	endfunction

	function automatic longint unsigned scale_lvl(longint unsigned tot, longint unsigned l);
		return (tot * l + HALF_L) >> FRAC_W;
	endfunction

	function automatic void schedule_period(input req_row_t it, ref phase_beat_t res [$]);
		longint unsigned now_v, run, remain, lv [3], tg, st, rr, a, s, s2, ld, q, rem;
		longint unsigned total, tp [4], grp [4], gl [4], off, on, all;
		longint d;
		logic done;
		int ord [3], r, g, gmax, x, k, i;
		res.delete();
		now_v = it.now;
		if (it.mode == MODE_FADE) begin
			for (i = 0; i < 3; i++) begin
				lvl_start[i] = lvl_cur[i];
				lvl_tgt[i] = it.lvl[i];
			end
			fade_t0 = (now_v - sh_margin) & TMASK_L;
			fade_len = it.len;
			if (fade_len == 0) fade_len = 1;
			return;
		end
		done = 0;
		run = (now_v - fade_t0) & TMASK_L;
		if (fade_len != 0) begin
			remain = (fade_len - run) & TMASK_L;
			if (remain[TIME_W-1] || remain < sh_margin) begin
				fade_len = 0;
				fade_t0 = 0;
				done = 1;
				for (i = 0; i < 3; i++) lvl_cur[i] = lvl_tgt[i];
			end
		end
		for (i = 0; i < 3; i++) begin
			tg = clamp_lvl(lvl_tgt[i]);
			st = clamp_lvl(lvl_start[i]);
			ld = tg;
			if (fade_len != 0 && st != tg) begin
				if (run >= fade_len) rr = ONE_L;
				else begin
					q = 0;
					rem = run;
					for (k = 0; k < FRAC_W; k++) begin
						rem = rem << 1;
						q = q << 1;
						if (rem >= fade_len) begin
							rem -= fade_len;
							q |= 1;
						end
					end
					rr = q;
				end
				if (st < tg) a = st;
				else begin
					a = tg;
					rr = ONE_L - rr;
				end
				s = a + (((ONE_L - a) * rr + HALF_L) >> FRAC_W);
				s2 = (s * s + HALF_L) >> FRAC_W;
				ld = (tg * s2 + HALF_L) >> FRAC_W;
			end
			lv[i] = clamp_lvl(ld);
		end
		ord = '{0, 1, 2};
		if (lv[ord[0]] > lv[ord[1]]) begin x = ord[0]; ord[0] = ord[1]; ord[1] = x; end
		if (lv[ord[1]] > lv[ord[2]]) begin x = ord[1]; ord[1] = ord[2]; ord[2] = x; end
		if (lv[ord[0]] > lv[ord[1]]) begin x = ord[0]; ord[0] = ord[1]; ord[1] = x; end
		for (g = 0; g < 4; g++) begin
			grp[g] = 0;
			gl[g] = 0;
			tp[g] = 0;
		end
		off = 0;
		on = 0;
		for (r = 0; r < 3 && lv[ord[r]] == 0; r++) off |= 64'd1 << ord[r];
		for (g = 0; r < 3 && lv[ord[r]] < ONE_L; r++) begin
			g++;
			grp[g] = 64'd1 << ord[r];
			gl[g] = lv[ord[r]];
		end
		for (; r < 3; r++) on |= 64'd1 << ord[r];
		if (g == 0) begin
			res.push_back('{2'd0, 3'd0, 20'd0, off[2:0], on[2:0], done, 1'b1, 1'b1});
			return;
		end
		gmax = g;
		if (gl[1] * sh_base < sh_min_phase * ONE_L) begin
			tp[1] = sh_min_phase;
			total = (2 * sh_min_phase * ONE_L + gl[1]) / (2 * gl[1]);
			if (total > sh_max) total = sh_max;
			for (g = 2; g <= gmax; g++) begin
				tp[g] = scale_lvl(total, gl[g]);
				if (tp[g] < sh_min_phase) tp[g] = sh_min_phase;
			end
		end else begin
			total = sh_base;
			for (g = 1; g <= gmax; g++) begin
				tp[g] = scale_lvl(total, gl[g]);
				if (tp[g] < sh_min_phase) tp[g] = sh_min_phase;
			end
		end
		for (g = 2; g <= gmax; g++) begin
			d = longint'(tp[g]) - longint'(tp[g-1]);
			if (d < longint'(sh_min_phase)) begin
				grp[g-1] |= grp[g];
				for (r = g; r < gmax; r++) begin
					grp[r] = grp[r+1];
					tp[r] = tp[r+1];
				end
				grp[gmax] = 0;
				tp[gmax] = 0;
				gmax--;
				g--;
			end
		end
		tp[0] = total > tp[gmax] ? total - tp[gmax] : 0;
		for (g = 2; g <= gmax; g++) tp[g] -= tp[g-1];
		all = 0;
		for (g = 1; g <= gmax; g++) all |= grp[g];
		res.push_back('{2'd0, all[2:0], tp[0][19:0], off[2:0], on[2:0], done, 1'b0, 1'b0});
		for (k = 1; k <= gmax; k++)
			res.push_back('{k[1:0], grp[k][2:0], tp[k][19:0], off[2:0], on[2:0], done,
				1'b0, k == gmax});
	endfunction

	task automatic write_reg(input logic [1:0] idx, input longint unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[19:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_PHASE:   sh_min_phase = val & 64'hFFFF;
			REG_BASE_PERIOD: sh_base = val & 64'hFFFFF;
			REG_MAX_PERIOD:  sh_max = val & 64'hFFFFF;
			REG_END_MARGIN:  sh_margin = val & 64'hFFFFF;
		endcase
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		wait (sched_q.size() == 0);
		@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic send(input req_row_t it);
		phase_beat_t res [$];
		if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= it.mode;
		req_ch.now_time <= it.now;
		req_ch.fade_length <= it.len;
		req_ch.target_red <= it.lvl[0];
		req_ch.target_green <= it.lvl[1];
		req_ch.target_blue <= it.lvl[2];
		do @(posedge clk); while (!req_ch.ready);
		schedule_period(it, res);
		if (it.n_typed > 0) begin
			if (res.size() != 1 || res[0] !== it.typed) begin
				errors++;
				$display("%0t directed row mismatch: exp %p act %p", $time, it.typed,
					res.size() ? res[0] : '0);
			end
			sched_q.push_back(it.typed);
		end else begin
			foreach (res[i]) sched_q.push_back(res[i]);
		end
		n_sent++;
		@(negedge clk);
	endtask

	function automatic logic [LVL_W-1:0] pick_level();
		case ($urandom_range(9))
			0: return '0;
			1: return LVL_ONE;
			2: return LVL_W'($urandom_range(65537, 131071));
			3: return LVL_W'($urandom_range(1, 300));
			4: return LVL_W'(65536 - $urandom_range(1, 300));
			default: return LVL_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic req_row_t mk(logic m, longint unsigned now, longint unsigned len,
		int r, int g, int b);
		req_row_t it;
		it.mode = m;
		it.now = now[31:0];
		it.len = len[31:0];
		it.lvl[0] = LVL_W'(r);
		it.lvl[1] = LVL_W'(g);
		it.lvl[2] = LVL_W'(b);
		it.n_typed = 0;
		it.typed = '0;
		return it;
	endfunction

	task automatic random_items(input int count);
		req_row_t it;
		longint unsigned len;
		int n0, k;
		n0 = n_sent;
		while (n_sent - n0 < count) begin
			if ($urandom_range(9) == 0) begin
				it = mk($urandom_range(1), $urandom, $urandom, 0, 0, 0);
				foreach (it.lvl[i]) it.lvl[i] = LVL_W'($urandom);
				send(it);
			end else begin
				case ($urandom_range(5))
					0: len = 0;
					1: len = $urandom;
					2: len = $urandom_range(1, 300000);
					default: len = $urandom_range(1, 40000);
				endcase
				if ($urandom_range(7) == 0) tcur = $urandom;
				it = mk(MODE_FADE, tcur, len, 0, 0, 0);
				foreach (it.lvl[i]) it.lvl[i] = pick_level();
				send(it);
				for (k = $urandom_range(1, 4); k > 0; k--) begin
					tcur = (tcur + $urandom_range(0, (len > 200000 ? 200000 : len) / 2 + 3000))
						& TMASK_L;
					it = mk(1'b1, tcur, $urandom, $urandom, $urandom, $urandom);
					send(it);
				end
			end
		end
	endtask

	initial begin
		req_row_t rows [$];
		req_row_t it;
		int ph;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = 1'b0;
		req_ch.now_time = '0;
		req_ch.fade_length = '0;
		req_ch.target_red = '0;
		req_ch.target_green = '0;
		req_ch.target_blue = '0;
		sched_ch.ready = 1'b0;
		sh_min_phase = 250;
		sh_base = 5000;
		sh_max = 50000;
		sh_margin = 5000;
		for (int i = 0; i < 3; i++) begin
			lvl_start[i] = 0;
			lvl_tgt[i] = 0;
			lvl_cur[i] = 0;
		end
		fade_t0 = 0;
		fade_len = 0;
		n_sent = 0;
		tcur = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all dark after reset
		it = mk(1'b1, 0, 0, 0, 0, 0);
		it.n_typed = 1;
		it.typed = '{2'd0, 3'd0, 20'd0, 3'd7, 3'd0, 1'b0, 1'b1, 1'b1};
		rows.push_back(it);
		// immediate fade to full
		rows.push_back(mk(MODE_FADE, 1000, 0, 65536, 65536, 65536));
		it = mk(1'b1, 1000, 0, 0, 0, 0);
		it.n_typed = 1;
		it.typed = '{2'd0, 3'd0, 20'd0, 3'd0, 3'd7, 1'b1, 1'b1, 1'b1};
		rows.push_back(it);
		// over-range target clamps to full
		rows.push_back(mk(MODE_FADE, 32'hFFFF_FFFF, 0, 131071, 0, 65536));
		it = mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 131071, 131071, 131071);
		it.n_typed = 1;
		it.typed = '{2'd0, 3'd0, 20'd0, 3'd2, 3'd5, 1'b1, 1'b1, 1'b1};
		rows.push_back(it);
		rows.push_back(mk(MODE_FADE, 0, 100000, 32768, 1, 65535));
		rows.push_back(mk(1'b1, 0, 0, 0, 0, 0));
		rows.push_back(mk(1'b1, 20000, 0, 0, 0, 0));
		rows.push_back(mk(1'b1, 60000, 0, 0, 0, 0));
		rows.push_back(mk(1'b1, 94000, 0, 0, 0, 0));
		rows.push_back(mk(1'b1, 94000, 0, 0, 0, 0));
		rows.push_back(mk(MODE_FADE, 12345, 32'hFFFF_FFFF, 100, 30000, 65000));
		rows.push_back(mk(1'b1, 12355, 0, 0, 0, 0));
		rows.push_back(mk(1'b1, 32'h8000_0000, 0, 0, 0, 0));
		rows.push_back(mk(MODE_FADE, 5, 1, 3, 3, 3));
		rows.push_back(mk(1'b1, 5, 0, 0, 0, 0));
		rows.push_back(mk(MODE_FADE, 7, 50000, 65536, 65536, 0));
		rows.push_back(mk(1'b1, 30000, 0, 0, 0, 0));
		rows.push_back(mk(MODE_FADE, 40000, 60000, 2, 40000, 40100));
		rows.push_back(mk(1'b1, 45000, 0, 0, 0, 0));
		rows.push_back(mk(1'b1, 70000, 0, 0, 0, 0));

		for (ph = 0; ph < 6; ph++) begin
			tx_idle = ph < 2 ? 37 : (ph < 4 ? 69 : 0);
			rx_idle = ph < 2 ? 69 : (ph < 4 ? 37 : 0);
			case (ph)
				1: begin
					write_reg(REG_MIN_PHASE, 1);
					write_reg(REG_BASE_PERIOD, 20'hFFFFF);
					write_reg(REG_MAX_PERIOD, 20'hFFFFF);
					write_reg(REG_END_MARGIN, 0);
				end
				2: begin
					write_reg(REG_MIN_PHASE, 16'hFFFF);
					write_reg(REG_BASE_PERIOD, 1);
					write_reg(REG_MAX_PERIOD, 1);
					write_reg(REG_END_MARGIN, 20'hFFFFF);
				end
				4: begin
					write_reg(REG_MIN_PHASE, 250);
					write_reg(REG_BASE_PERIOD, 5000);
					write_reg(REG_MAX_PERIOD, 50000);
					write_reg(REG_END_MARGIN, 5000);
				end
				3, 5: begin
					write_reg(REG_MIN_PHASE, $urandom_range(50, 2000));
					write_reg(REG_BASE_PERIOD, $urandom_range(2000, 100000));
					write_reg(REG_MAX_PERIOD, $urandom_range(100000, 20'hFFFFF));
					write_reg(REG_END_MARGIN, $urandom_range(0, 20000));
				end
				default: ;
			endcase
			if (ph == 0)
				foreach (rows[i]) send(rows[i]);
			if (ph == 2) rx_hold = 3000;
			random_items(33);
			if (ph == 3) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
				wait (sched_q.size() == 0);
				@(negedge clk);
			end
			random_items(33);
			drain();
		end

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### sim.f
design/rfps_pkg.sv
design/rfps_req_if.sv
design/rfps_sched_if.sv
design/rfps_ctrl.sv
design/rfps_dp.sv
design/rgb_fade_pwm_phase_scheduler.sv
verif/rgb_fade_pwm_phase_scheduler_tb.sv
